FILE: design/boids_pkg.sv
package boids_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_COHESION_EN   = 3'd0;
    localparam logic [2:0] REG_SEPARATION_EN = 3'd1;
    localparam logic [2:0] REG_ALIGNMENT_EN  = 3'd2;
    localparam logic [2:0] REG_X_BOUND       = 3'd3;
    localparam logic [2:0] REG_Y_BOUND       = 3'd4;
    localparam logic [2:0] REG_MAX_SPEED     = 3'd5;
    localparam logic [2:0] REG_BOID_COUNT    = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Command carried in s_tuser
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Fixed widths of the stream fields
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 136;

    localparam int STATE_W = 13;

    typedef enum logic [STATE_W-1:0] {
        S_IDLE  = 13'b0000000000001,
        S_FETCH = 13'b0000000000010,
        S_FWAIT = 13'b0000000000100,
        S_SCAN  = 13'b0000000001000,
        S_DRAIN = 13'b0000000010000,
        S_DSET  = 13'b0000000100000,
        S_DITER = 13'b0000001000000,
        S_DEND  = 13'b0000010000000,
        S_COMB  = 13'b0000100000000,
        S_MUL   = 13'b0001000000000,
        S_SCALE = 13'b0010000000000,
        S_POS   = 13'b0100000000000,
        S_EMIT  = 13'b1000000000000
    } state_t;

endpackage

FILE: design/boids_flocking_step.sv
// Boids flocking step. A load transfer (s_tuser = 0) writes one boid's position and
// velocity into the boid store. A step transfer (s_tuser = 1) updates boids 0 to n-1,
// with n the boid count held to 2..MAX_BOIDS, in order and in place, giving one result
// transfer per boid with m_tlast on the last. Each boid first scans the store once
// through a single read port, then runs four divisions (cohesion and alignment on each
// axis) one after the other on one shared restoring divider of one quotient bit per
// cycle, then velocity sum, clamp and position update on one shared multiplier. The
// block takes no new item while a step runs; a result waiting in the output register
// holds the block only at the end of the next boid. The store is not cleared: a step
// must only read boids that were loaded.
module boids_flocking_step #(
    parameter int MAX_BOIDS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // boid_index[4:0], load_pos_x[36:5], load_pos_y[68:37], load_vel_x[100:69],
    // load_vel_y[132:101], time_step[148:133], zero fill above
    input  logic [boids_pkg::IN_DATA_W-1:0]        s_tdata,
    // cmd
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // out_index[4:0], new_pos_x[36:5], new_pos_y[68:37], new_vel_x[100:69],
    // new_vel_y[132:101], zero fill above
    output logic [boids_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                   m_tlast,
    input  logic                                   cfg_we,
    input  logic [boids_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [boids_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int IDX_W  = $clog2(MAX_BOIDS);
    localparam int CNT_W  = $clog2(MAX_BOIDS + 1);
    localparam int SUM_W  = 33 + CNT_W;          // sums over the other boids
    localparam int DV_W   = CNT_W + 7;           // divisor, up to (n-1)*100
    localparam int DCNT_W = $clog2(SUM_W + 1);
    localparam int V_W    = SUM_W + 3;           // unclamped velocity
    localparam int CMP_W  = (17 + FRAC_BITS > 33) ? 17 + FRAC_BITS : 33;
    localparam int PR_W   = 49;                  // velocity times dt
    localparam int T_W    = 54;                  // times 25
    localparam int DL_W   = 38;                  // position change
    localparam logic signed [32:0]    NEAR = 33'(10) << FRAC_BITS;
    localparam logic signed [V_W-1:0] PUSH = V_W'(10) << FRAC_BITS;

    // Boid store
    logic [31:0] mem_px [MAX_BOIDS];
    logic [31:0] mem_py [MAX_BOIDS];
    logic [31:0] mem_vx [MAX_BOIDS];
    logic [31:0] mem_vy [MAX_BOIDS];
    logic [31:0] rd_px_reg, rd_py_reg, rd_vx_reg, rd_vy_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [31:0]      mem_wpx, mem_wpy, mem_wvx, mem_wvy;

    boids_pkg::state_t state_reg, state_next;

    logic             coh_en_reg, coh_en_next, sep_en_reg, sep_en_next;
    logic             ali_en_reg, ali_en_next;
    logic [15:0]      xb_reg, xb_next, yb_reg, yb_next;
    logic [30:0]      maxs_reg, maxs_next;
    logic [5:0]       bcnt_reg, bcnt_next;

    logic [15:0]      dt_reg, dt_next;
    logic [CNT_W-1:0] m_reg, m_next;
    logic [IDX_W-1:0] lastidx_reg, lastidx_next;
    logic [DV_W-1:0]  div100_reg, div100_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic             accv_reg, accv_next;
    logic [31:0]      pix_reg, pix_next, piy_reg, piy_next;
    logic [31:0]      vix_reg, vix_next, viy_reg, viy_next;
    logic signed [SUM_W-1:0] spx_reg, spx_next, spy_reg, spy_next;
    logic signed [SUM_W-1:0] svx_reg, svx_next, svy_reg, svy_next;
    logic signed [SUM_W-1:0] sepx_reg, sepx_next, sepy_reg, sepy_next;
    logic [1:0]       dsel_reg, dsel_next;
    logic [SUM_W-1:0] dq_reg, dq_next;
    logic [DV_W-1:0]  dr_reg, dr_next, dd_reg, dd_next;
    logic             dneg_reg, dneg_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic signed [SUM_W-1:0] cohx_reg, cohx_next, cohy_reg, cohy_next;
    logic signed [SUM_W-1:0] alix_reg, alix_next, aliy_reg, aliy_next;
    logic [31:0]      vnx_reg, vnx_next, vny_reg, vny_next;
    logic             axis_reg, axis_next;
    logic signed [PR_W-1:0] prod_reg, prod_next;
    logic signed [DL_W-1:0] delta_reg, delta_next;
    logic [31:0]      pnx_reg, pnx_next, pny_reg, pny_next;
    logic             ovld_reg, ovld_next, olast_reg, olast_next;
    logic [4:0]       oidx_reg, oidx_next;
    logic [31:0]      opx_reg, opx_next, opy_reg, opy_next;
    logic [31:0]      ovx_reg, ovx_next, ovy_reg, ovy_next;

    // Boundary push on one axis
    function automatic logic signed [V_W-1:0] push_f(input logic [31:0] p,
                                                     input logic [15:0] bound);
        logic signed [CMP_W-1:0] pe;
        logic signed [CMP_W-1:0] edge_v;
        pe     = CMP_W'($signed(p));
        edge_v = CMP_W'(bound) << FRAC_BITS;
        if (pe > edge_v)
            return -PUSH;
        else if (pe < 0)
            return PUSH;
        else
            return '0;
    endfunction

    // Clamp one velocity axis to the speed limit
    function automatic logic [31:0] clamp_f(input logic signed [V_W-1:0] v,
                                            input logic [30:0] lim);
        logic signed [V_W-1:0] l;
        l = V_W'(lim);
        if (v > l)
            return 32'(l);
        else if (v < -l)
            return 32'(-l);
        else
            return 32'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_px[mem_wa] <= mem_wpx;
            mem_py[mem_wa] <= mem_wpy;
            mem_vx[mem_wa] <= mem_wvx;
            mem_vy[mem_wa] <= mem_wvy;
        end
        rd_px_reg <= mem_px[rd_addr];
        rd_py_reg <= mem_py[rd_addr];
        rd_vx_reg <= mem_vx[rd_addr];
        rd_vy_reg <= mem_vy[rd_addr];
    end

    logic                     s_fire;
    logic signed [32:0]       dx, dy;
    logic signed [SUM_W-1:0]  dnum, dprod;
    logic signed [31:0]       dpsel;
    logic signed [SUM_W-1:0]  dssel;
    logic [DV_W:0]            rsh;
    logic [DV_W+1:0]          rdiff;
    logic signed [SUM_W-1:0]  dres;
    logic signed [V_W-1:0]    vsx, vsy;
    logic signed [T_W-1:0]    t25, tadj;
    logic signed [DL_W:0]     psum;
    logic [31:0]              psat;
    logic                     emit_go;

    assign s_tready = (state_reg == boids_pkg::S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        coh_en_next  = coh_en_reg;
        sep_en_next  = sep_en_reg;
        ali_en_next  = ali_en_reg;
        xb_next      = xb_reg;
        yb_next      = yb_reg;
        maxs_next    = maxs_reg;
        bcnt_next    = bcnt_reg;
        dt_next      = dt_reg;
        m_next       = m_reg;
        lastidx_next = lastidx_reg;
        div100_next  = div100_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        accv_next    = accv_reg;
        pix_next     = pix_reg;
        piy_next     = piy_reg;
        vix_next     = vix_reg;
        viy_next     = viy_reg;
        spx_next     = spx_reg;
        spy_next     = spy_reg;
        svx_next     = svx_reg;
        svy_next     = svy_reg;
        sepx_next    = sepx_reg;
        sepy_next    = sepy_reg;
        dsel_next    = dsel_reg;
        dq_next      = dq_reg;
        dr_next      = dr_reg;
        dd_next      = dd_reg;
        dneg_next    = dneg_reg;
        dcnt_next    = dcnt_reg;
        cohx_next    = cohx_reg;
        cohy_next    = cohy_reg;
        alix_next    = alix_reg;
        aliy_next    = aliy_reg;
        vnx_next     = vnx_reg;
        vny_next     = vny_reg;
        axis_next    = axis_reg;
        prod_next    = prod_reg;
        delta_next   = delta_reg;
        pnx_next     = pnx_reg;
        pny_next     = pny_reg;
        ovld_next    = ovld_reg;
        olast_next   = olast_reg;
        oidx_next    = oidx_reg;
        opx_next     = opx_reg;
        opy_next     = opy_reg;
        ovx_next     = ovx_reg;
        ovy_next     = ovy_reg;

        rd_addr = i_reg;
        mem_we  = 1'b0;
        mem_wa  = i_reg;
        mem_wpx = pnx_reg;
        mem_wpy = pny_reg;
        mem_wvx = vnx_reg;
        mem_wvy = vny_reg;

        dx    = $signed({pix_reg[31], pix_reg}) - $signed({rd_px_reg[31], rd_px_reg});
        dy    = $signed({piy_reg[31], piy_reg}) - $signed({rd_py_reg[31], rd_py_reg});
        dpsel = '0;
        dssel = '0;
        case (dsel_reg)
            2'd0:    begin dpsel = $signed(pix_reg); dssel = spx_reg; end
            2'd1:    begin dpsel = $signed(piy_reg); dssel = spy_reg; end
            2'd2:    begin dpsel = $signed(vix_reg); dssel = svx_reg; end
            default: begin dpsel = $signed(viy_reg); dssel = svy_reg; end
        endcase
        dprod = SUM_W'($signed({1'b0, m_reg}) * dpsel);
        dnum  = dssel - dprod;
        rsh   = {dr_reg, dq_reg[SUM_W-1]};
        rdiff = {1'b0, rsh} - {2'b00, dd_reg};
        dres  = dneg_reg ? -$signed(dq_reg) : $signed(dq_reg);

        vsx = V_W'($signed(vix_reg)) + push_f(pix_reg, xb_reg);
        vsy = V_W'($signed(viy_reg)) + push_f(piy_reg, yb_reg);
        if (coh_en_reg)
        begin
            vsx = vsx + V_W'(cohx_reg);
            vsy = vsy + V_W'(cohy_reg);
        end
        if (sep_en_reg)
        begin
            vsx = vsx + V_W'(sepx_reg);
            vsy = vsy + V_W'(sepy_reg);
        end
        if (ali_en_reg)
        begin
            vsx = vsx + V_W'(alix_reg);
            vsy = vsy + V_W'(aliy_reg);
        end

        t25  = (T_W'(prod_reg) <<< 4) + (T_W'(prod_reg) <<< 3) + T_W'(prod_reg);
        tadj = t25[T_W-1] ? t25 + T_W'(65535) : t25;

        psum = (DL_W+1)'($signed(axis_reg ? piy_reg : pix_reg)) + (DL_W+1)'(delta_reg);
        if (psum > (DL_W+1)'(32'sh7FFFFFFF))
            psat = 32'h7FFFFFFF;
        else if (psum < -(DL_W+1)'(33'sh080000000))
            psat = 32'h80000000;
        else
            psat = 32'(psum);

        emit_go = !ovld_reg || m_tready;

        // Drop the result once the sink takes it
        if (ovld_reg && m_tready)
            ovld_next = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                boids_pkg::REG_COHESION_EN:   coh_en_next = cfg_wdata[0];
                boids_pkg::REG_SEPARATION_EN: sep_en_next = cfg_wdata[0];
                boids_pkg::REG_ALIGNMENT_EN:  ali_en_next = cfg_wdata[0];
                boids_pkg::REG_X_BOUND:       xb_next     = cfg_wdata[15:0];
                boids_pkg::REG_Y_BOUND:       yb_next     = cfg_wdata[15:0];
                boids_pkg::REG_MAX_SPEED:     maxs_next   = cfg_wdata;
                boids_pkg::REG_BOID_COUNT:    bcnt_next   = cfg_wdata[5:0];
                default: ;
            endcase
        end

        case (state_reg)
            boids_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    if (s_tuser == boids_pkg::CMD_LOAD)
                    begin
                        mem_we  = (32'(s_tdata[4:0]) < MAX_BOIDS);
                        mem_wa  = IDX_W'(s_tdata[4:0]);
                        mem_wpx = s_tdata[36:5];
                        mem_wpy = s_tdata[68:37];
                        mem_wvx = s_tdata[100:69];
                        mem_wvy = s_tdata[132:101];
                    end
                    else
                    begin
                        dt_next = s_tdata[148:133];
                        if (bcnt_reg < 6'd2)
                            m_next = CNT_W'(1);
                        else if (32'(bcnt_reg) > MAX_BOIDS)
                            m_next = CNT_W'(MAX_BOIDS - 1);
                        else
                            m_next = CNT_W'(bcnt_reg - 6'd1);
                        lastidx_next = IDX_W'(m_next);
                        div100_next  = DV_W'(m_next) * DV_W'(100);
                        i_next       = '0;
                        state_next   = boids_pkg::S_FETCH;
                    end
                end
            end
            boids_pkg::S_FETCH:
            begin
                rd_addr    = i_reg;
                state_next = boids_pkg::S_FWAIT;
            end
            boids_pkg::S_FWAIT:
            begin
                pix_next   = rd_px_reg;
                piy_next   = rd_py_reg;
                vix_next   = rd_vx_reg;
                viy_next   = rd_vy_reg;
                spx_next   = '0;
                spy_next   = '0;
                svx_next   = '0;
                svy_next   = '0;
                sepx_next  = '0;
                sepy_next  = '0;
                j_next     = '0;
                accv_next  = 1'b0;
                state_next = boids_pkg::S_SCAN;
            end
            boids_pkg::S_SCAN,
            boids_pkg::S_DRAIN:
            begin
                if (accv_reg)
                begin
                    spx_next = spx_reg + SUM_W'($signed(rd_px_reg));
                    spy_next = spy_reg + SUM_W'($signed(rd_py_reg));
                    svx_next = svx_reg + SUM_W'($signed(rd_vx_reg));
                    svy_next = svy_reg + SUM_W'($signed(rd_vy_reg));
                    if ((dx < NEAR) && (dx > -NEAR))
                        sepx_next = sepx_reg + SUM_W'(dx);
                    if ((dy < NEAR) && (dy > -NEAR))
                        sepy_next = sepy_reg + SUM_W'(dy);
                end
                if (state_reg == boids_pkg::S_SCAN)
                begin
                    rd_addr   = j_reg;
                    accv_next = (j_reg != i_reg);
                    if (j_reg == lastidx_reg)
                        state_next = boids_pkg::S_DRAIN;
                    else
                        j_next = j_reg + 1'b1;
                end
                else
                begin
                    accv_next  = 1'b0;
                    dsel_next  = 2'd0;
                    state_next = boids_pkg::S_DSET;
                end
            end
            boids_pkg::S_DSET:
            begin
                dneg_next  = dnum[SUM_W-1];
                dq_next    = dnum[SUM_W-1] ? SUM_W'(-dnum) : SUM_W'(dnum);
                dr_next    = '0;
                dd_next    = dsel_reg[1] ? DV_W'(m_reg) << 3 : div100_reg;
                dcnt_next  = DCNT_W'(SUM_W);
                state_next = boids_pkg::S_DITER;
            end
            boids_pkg::S_DITER:
            begin
                // One restoring step: shift in a dividend bit, subtract if it fits
                if (!rdiff[DV_W+1])
                begin
                    dr_next = rdiff[DV_W-1:0];
                    dq_next = {dq_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    dr_next = rsh[DV_W-1:0];
                    dq_next = {dq_reg[SUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCNT_W'(1))
                    state_next = boids_pkg::S_DEND;
            end
            boids_pkg::S_DEND:
            begin
                case (dsel_reg)
                    2'd0:    cohx_next = dres;
                    2'd1:    cohy_next = dres;
                    2'd2:    alix_next = dres;
                    default: aliy_next = dres;
                endcase
                dsel_next = dsel_reg + 1'b1;
                if (dsel_reg == 2'd3)
                    state_next = boids_pkg::S_COMB;
                else
                    state_next = boids_pkg::S_DSET;
            end
            boids_pkg::S_COMB:
            begin
                vnx_next   = clamp_f(vsx, maxs_reg);
                vny_next   = clamp_f(vsy, maxs_reg);
                axis_next  = 1'b0;
                state_next = boids_pkg::S_MUL;
            end
            boids_pkg::S_MUL:
            begin
                prod_next  = PR_W'($signed(axis_reg ? vny_reg : vnx_reg)
                             * $signed({1'b0, dt_reg}));
                state_next = boids_pkg::S_SCALE;
            end
            boids_pkg::S_SCALE:
            begin
                delta_next = DL_W'(tadj >>> 16);
                state_next = boids_pkg::S_POS;
            end
            boids_pkg::S_POS:
            begin
                if (axis_reg)
                begin
                    pny_next   = psat;
                    state_next = boids_pkg::S_EMIT;
                end
                else
                begin
                    pnx_next   = psat;
                    axis_next  = 1'b1;
                    state_next = boids_pkg::S_MUL;
                end
            end
            boids_pkg::S_EMIT:
            begin
                // Hold until the output register is free, then write back and send
                if (emit_go)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = i_reg;
                    ovld_next  = 1'b1;
                    olast_next = (i_reg == lastidx_reg);
                    oidx_next  = 5'(i_reg);
                    opx_next   = pnx_reg;
                    opy_next   = pny_reg;
                    ovx_next   = vnx_reg;
                    ovy_next   = vny_reg;
                    if (i_reg == lastidx_reg)
                        state_next = boids_pkg::S_IDLE;
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = boids_pkg::S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = boids_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= boids_pkg::S_IDLE;
            coh_en_reg <= 1'b1;
            sep_en_reg <= 1'b1;
            ali_en_reg <= 1'b1;
            xb_reg     <= 16'd1024;
            yb_reg     <= 16'd1024;
            maxs_reg   <= 31'd262144;
            bcnt_reg   <= 6'd32;
            ovld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            coh_en_reg <= coh_en_next;
            sep_en_reg <= sep_en_next;
            ali_en_reg <= ali_en_next;
            xb_reg     <= xb_next;
            yb_reg     <= yb_next;
            maxs_reg   <= maxs_next;
            bcnt_reg   <= bcnt_next;
            ovld_reg   <= ovld_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dt_reg      <= dt_next;
        m_reg       <= m_next;
        lastidx_reg <= lastidx_next;
        div100_reg  <= div100_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        accv_reg    <= accv_next;
        pix_reg     <= pix_next;
        piy_reg     <= piy_next;
        vix_reg     <= vix_next;
        viy_reg     <= viy_next;
        spx_reg     <= spx_next;
        spy_reg     <= spy_next;
        svx_reg     <= svx_next;
        svy_reg     <= svy_next;
        sepx_reg    <= sepx_next;
        sepy_reg    <= sepy_next;
        dsel_reg    <= dsel_next;
        dq_reg      <= dq_next;
        dr_reg      <= dr_next;
        dd_reg      <= dd_next;
        dneg_reg    <= dneg_next;
        dcnt_reg    <= dcnt_next;
        cohx_reg    <= cohx_next;
        cohy_reg    <= cohy_next;
        alix_reg    <= alix_next;
        aliy_reg    <= aliy_next;
        vnx_reg     <= vnx_next;
        vny_reg     <= vny_next;
        axis_reg    <= axis_next;
        prod_reg    <= prod_next;
        delta_reg   <= delta_next;
        pnx_reg     <= pnx_next;
        pny_reg     <= pny_next;
        olast_reg   <= olast_next;
        oidx_reg    <= oidx_next;
        opx_reg     <= opx_next;
        opy_reg     <= opy_next;
        ovx_reg     <= ovx_next;
        ovy_reg     <= ovy_next;
    end

    assign m_tvalid = ovld_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {3'b000, ovy_reg, ovx_reg, opy_reg, opx_reg, oidx_reg};

endmodule
